FILE: src/tss_pkg.sv
// Shared constants and control types for the two-stack shared-memory block.
package tss_pkg;

	localparam int CMD_W    = 2;
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH_LOW  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_HIGH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POP_LOW   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_POP_HIGH  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;   // an input item is accepted this cycle
		logic finish;  // memory read data of a pop is ready to be captured
	} tss_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pop_go;  // current command is a pop on a non-empty stack
	} tss_sts_t;

endpackage

FILE: src/tss_ram.sv
// Generic single-port RAM with registered read data.
module tss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: src/tss_ctrl.sv
// Controller state machine: input and output handshakes and pop sequencing.
module tss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  tss_pkg::tss_sts_t sts,
	output tss_pkg::tss_ctrl_t ctrl
);
	import tss_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_set;

	// A new item may enter when no pop read is pending and the output register is free at this edge.
	assign in_ready    = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign ctrl.start  = accept;
	assign ctrl.finish = (state_q == S_READ);

	// The result register fills when an item finishes at once or when a pop read completes.
	assign out_set = (accept && !sts.pop_go) || (state_q == S_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && sts.pop_go) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/tss_dp.sv
// Datapath: stack counts, address generation, shared memory and result register.
module tss_dp #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tss_pkg::CMD_W-1:0]     command,
	input  logic [tss_pkg::DATA_W-1:0]    data,
	input  tss_pkg::tss_ctrl_t            ctrl,
	output tss_pkg::tss_sts_t             sts,
	output logic [tss_pkg::DATA_W-1:0]    pop_data,
	output logic [tss_pkg::STATUS_W-1:0]  status
);
	import tss_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam logic [CW:0] DEPTH_C = (CW + 1)'(DEPTH);

	logic [CW-1:0]       count_low_q, count_high_q;
	logic [CW:0]         used;
	logic                full, low_empty, high_empty;
	logic [CW:0]         addr_wide;
	logic [AW-1:0]       ram_addr;
	logic                ram_we;
	logic [DATA_W-1:0]   ram_rdata;
	logic [DATA_W-1:0]   pop_data_q;
	logic [STATUS_W-1:0] status_q;

	assign used       = {1'b0, count_low_q} + {1'b0, count_high_q};
	assign full       = (used >= DEPTH_C);
	assign low_empty  = (count_low_q == '0);
	assign high_empty = (count_high_q == '0);

	assign sts.pop_go = ((command == CMD_POP_LOW) && !low_empty) ||
	                    ((command == CMD_POP_HIGH) && !high_empty);

	// Stack two's next free entry sits at DEPTH-1-count; its popped entry at DEPTH-count.
	always_comb begin
		ram_we    = 1'b0;
		addr_wide = '0;
		case (command)
			CMD_PUSH_LOW: begin
				addr_wide = {1'b0, count_low_q};
				ram_we    = ctrl.start && !full;
			end
			CMD_PUSH_HIGH: begin
				addr_wide = DEPTH_C - (CW + 1)'(1) - {1'b0, count_high_q};
				ram_we    = ctrl.start && !full;
			end
			CMD_POP_LOW: begin
				addr_wide = {1'b0, count_low_q} - (CW + 1)'(1);
			end
			default: begin
				addr_wide = DEPTH_C - {1'b0, count_high_q};
			end
		endcase
	end

	assign ram_addr = addr_wide[AW-1:0];

	tss_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(data),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_low_q  <= '0;
			count_high_q <= '0;
		end else if (ctrl.start) begin
			case (command)
				CMD_PUSH_LOW: begin
					if (!full) count_low_q <= count_low_q + CW'(1);
				end
				CMD_PUSH_HIGH: begin
					if (!full) count_high_q <= count_high_q + CW'(1);
				end
				CMD_POP_LOW: begin
					if (!low_empty) count_low_q <= count_low_q - CW'(1);
				end
				default: begin
					if (!high_empty) count_high_q <= count_high_q - CW'(1);
				end
			endcase
		end
	end

	// Pushes and failed pops finish at once; a good pop waits for the read data.
	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			pop_data_q <= ram_rdata;
			status_q   <= ST_OK;
		end else if (ctrl.start && !sts.pop_go) begin
			pop_data_q <= '0;
			if (command == CMD_PUSH_LOW || command == CMD_PUSH_HIGH) begin
				status_q <= full ? ST_OVERFLOW : ST_OK;
			end else begin
				status_q <= ST_UNDERFLOW;
			end
		end
	end

	assign pop_data = pop_data_q;
	assign status   = status_q;

endmodule

FILE: src/two_stacks_shared_memory_top.sv
// Top level of the two-stack shared-memory block.
// Two byte stacks share one single-port memory of DEPTH entries: stack one grows up from
// entry 0, stack two grows down from entry DEPTH-1. Each input item carries a command and a
// byte and yields exactly one result item with pop_data and status (0 ok, 1 overflow,
// 2 underflow). Pushes and failed operations finish at once, so they can follow each other
// every cycle while results are taken; a successful pop waits for the read, as the memory port
// returns its read data in the cycle after the address. The result sits in an output
// register, and the next item is taken in the same cycle that the previous result is taken.
// The memory contents are not cleared at reset; only the two stack counts are.
module two_stacks_shared_memory_top #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tss_pkg::CMD_W-1:0]     command,
	input  logic [tss_pkg::DATA_W-1:0]    data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tss_pkg::DATA_W-1:0]    pop_data,
	output logic [tss_pkg::STATUS_W-1:0]  status
);
	import tss_pkg::*;

	tss_ctrl_t ctrl;
	tss_sts_t  sts;

	tss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.ctrl     (ctrl)
	);

	tss_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.command (command),
		.data    (data),
		.ctrl    (ctrl),
		.sts     (sts),
		.pop_data(pop_data),
		.status  (status)
	);

endmodule

FILE: src/tss_checker.sv
// Port-level checker for the two-stack block, bound to its top level.
module tss_props (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [tss_pkg::CMD_W-1:0]     command,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [tss_pkg::DATA_W-1:0]    pop_data,
	input logic [tss_pkg::STATUS_W-1:0]  status
);
	import tss_pkg::*;

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pop_data) && $stable(status))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_OVERFLOW || status == ST_UNDERFLOW))
		else $error("unknown status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> pop_data == '0)
		else $error("failed operation returned data");

	// A push finishes at once, so its result shows at the next edge.
	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command == CMD_PUSH_LOW || command == CMD_PUSH_HIGH)
		|=> out_valid && status != ST_UNDERFLOW && pop_data == '0)
		else $error("push result missing or wrong");

endmodule

bind two_stacks_shared_memory_top tss_props u_tss_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.command  (command),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.pop_data (pop_data),
	.status   (status)
);
